[rtl/pfsc_pkg.sv]
// ----------------------------------------------------------------------------
// pfsc_pkg: shared types and constants of the front panel setting controller
// Field widths, key codes, arithmetic constants and the panel view record.
// ----------------------------------------------------------------------------
package pfsc_pkg;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int KEY_W    = 2;
	localparam int LEVEL_W  = 7;
	localparam int VAL_W    = 14;
	localparam int SEL_W    = 2;

	// Default number of channels.
	localparam int CHANNELS_DEF = 3;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_NONE  = 2'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT  = 2'd1;
	localparam logic [KEY_W-1:0] KEY_ENTER = 2'd2;
	localparam logic [KEY_W-1:0] KEY_RIGHT = 2'd3;

	// Knob scaling: level = min(full - sample, clamp) / 40.
	// The divide by 40 is a shift by three and a reciprocal multiply for five.
	localparam logic [SAMPLE_W-1:0] KNOB_FULL   = 12'd4095;
	localparam logic [SAMPLE_W-1:0] LEVEL_CLAMP = 12'd4000;
	localparam int                  PRE_SHIFT   = 3;
	localparam int                  RECIP_W     = 8;
	localparam logic [RECIP_W-1:0]  RECIP_FIVE  = 8'd205;
	localparam int                  RECIP_SHIFT = 10;

	// Timer value scales.
	localparam logic [VAL_W-1:0] PCT_SCALE  = 14'd100;
	localparam logic [VAL_W-1:0] RELOAD_NUM = 14'd10000;

	// The divider retires two quotient bits per cycle.
	localparam int DIV_STEPS = VAL_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// What the panel shows for the selected channel.
	typedef struct packed {
		logic [SEL_W-1:0]   channel;
		logic               editing;
		logic               field;
		logic [LEVEL_W-1:0] duty;
		logic [LEVEL_W-1:0] freq;
		logic               changed;
	} panel_view_t;

endpackage

[rtl/pfsc_divider.sv]
// ----------------------------------------------------------------------------
// pfsc_divider: shared iterative divider
// Restoring division of a 14-bit dividend by a 7-bit divisor, two quotient
// bits per cycle. A done pulse follows the last step; the quotient holds.
// ----------------------------------------------------------------------------
module pfsc_divider
	import pfsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VAL_W-1:0]   dividend,
	input  logic [LEVEL_W-1:0] divisor,
	output logic               done,
	output logic [VAL_W-1:0]   quotient
);

	logic [LEVEL_W-1:0]   rem_q;
	logic [VAL_W-1:0]     quo_q;
	logic [LEVEL_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [LEVEL_W-1:0]   rem_nxt;
	logic [VAL_W-1:0]     quo_nxt;

	// Two dependent restoring steps on narrow values.
	always_comb begin
		logic [LEVEL_W:0] trial;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int i = 0; i < 2; i++) begin
			trial   = {rem_nxt, quo_nxt[VAL_W-1]};
			quo_nxt = {quo_nxt[VAL_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial      = trial - {1'b0, div_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = trial[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// A new division is never started while one is still running.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> cnt_q == '0)
		else $error("divider restarted while busy");

	// The done pulse comes in the cycle after the last step.
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cnt_q) == DIV_CNT_W'(1) && !$past(start))
		else $error("divider done without a final step");

endmodule

[rtl/pfsc_panel.sv]
// ----------------------------------------------------------------------------
// pfsc_panel: panel state and key handling
// Holds the per-channel duty and frequency settings, the channel selection,
// the mode and the edited field, and applies one scan when told to.
// ----------------------------------------------------------------------------
module pfsc_panel
	import pfsc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               apply,
	input  logic [LEVEL_W-1:0] level,
	input  logic [KEY_W-1:0]   key,
	output panel_view_t        view
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [LEVEL_W-1:0] duty_q [CHANNELS];
	logic [LEVEL_W-1:0] freq_q [CHANNELS];
	logic [CH_W-1:0]    ch_q;
	logic               editing_q;
	logic               field_q;
	logic [LEVEL_W-1:0] last_q;
	logic               changed_q;

	logic               write_en;
	logic [CH_W-1:0]    ch_dn;
	logic [CH_W-1:0]    ch_up;
	logic [2:0]         ch_ext;

	assign write_en = editing_q && (level != last_q);
	assign ch_dn    = (ch_q == '0) ? CH_W'(CHANNELS - 1) : ch_q - CH_W'(1);
	assign ch_up    = (ch_q == CH_W'(CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				duty_q[c] <= LEVEL_W'(2 * c + 1);
				freq_q[c] <= LEVEL_W'(2 * c + 2);
			end
			ch_q      <= '0;
			editing_q <= 1'b0;
			field_q   <= 1'b0;
			last_q    <= '0;
			changed_q <= 1'b0;
		end else if (apply) begin
			changed_q <= write_en;
			// The level is applied under the mode that was in force before the key.
			if (write_en) begin
				last_q <= level;
				if (!field_q) begin
					duty_q[ch_q] <= level;
				end else begin
					freq_q[ch_q] <= (level == '0) ? LEVEL_W'(1) : level;
				end
			end
			unique case (key)
				KEY_LEFT: begin
					if (editing_q) field_q <= ~field_q;
					else           ch_q    <= ch_dn;
				end
				KEY_RIGHT: begin
					if (editing_q) field_q <= ~field_q;
					else           ch_q    <= ch_up;
				end
				KEY_ENTER: begin
					editing_q <= ~editing_q;
				end
				KEY_NONE: begin
				end
			endcase
		end
	end

	assign ch_ext       = 3'(ch_q);
	assign view.channel = ch_ext[SEL_W-1:0];
	assign view.editing = editing_q;
	assign view.field   = field_q;
	assign view.duty    = duty_q[ch_q];
	assign view.freq    = freq_q[ch_q];
	assign view.changed = changed_q;

	// The selection never leaves the channel range.
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ch_q) < CHANNELS)
		else $error("channel index out of range");

	// A stored frequency of zero is never shown.
	a_freq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		view.freq != '0)
		else $error("zero frequency in store");

endmodule

[rtl/pwm_front_panel_setting_controller.sv]
// A request is accepted only while the sequencer is idle, and the next one
// waits until its result has been handed over. The shared divider runs twice
// per request, at two quotient bits per cycle; accept, apply, the two
// divider starts and the hand-over each take a sequencer state of their own.
// A finished result waits in the output register while the next request enters.
// Reset (arst_n low) restores the default channel settings and select mode at once.
// ----------------------------------------------------------------------------
// pwm_front_panel_setting_controller: PWM front panel setting controller
// Turns one panel scan (knob sample and key) into the updated selection and
// the selected channel's duty, frequency and timer compare and reload values.
// ----------------------------------------------------------------------------
module pwm_front_panel_setting_controller
	import pfsc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] knob_sample,
	input  logic [KEY_W-1:0]    key_code,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [SEL_W-1:0]    selected_channel,
	output logic                editing,
	output logic                edited_field,
	output logic [LEVEL_W-1:0]  shown_duty,
	output logic [LEVEL_W-1:0]  shown_freq,
	output logic                setting_changed,
	output logic [VAL_W-1:0]    compare_value,
	output logic [VAL_W-1:0]    reload_value
);

	// Sequencer states. Each request walks through them in order:
	// capture, apply the scan to the panel state, divide for the compare
	// value, divide for the reload value, then hand the result over.
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_APPLY    = 3'd1;
	localparam logic [2:0] ST_DIV_CMP  = 3'd2;
	localparam logic [2:0] ST_WAIT_CMP = 3'd3;
	localparam logic [2:0] ST_DIV_RLD  = 3'd4;
	localparam logic [2:0] ST_WAIT_RLD = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	localparam int CLAMP_W = SAMPLE_W - PRE_SHIFT;
	localparam int PROD_W  = RECIP_SHIFT + LEVEL_W;

	logic [2:0]          state_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    cmp_q;

	logic                out_valid_q;
	logic [SEL_W-1:0]    channel_q;
	logic                editing_q;
	logic                field_q;
	logic [LEVEL_W-1:0]  duty_q;
	logic [LEVEL_W-1:0]  freq_q;
	logic                changed_q;
	logic [VAL_W-1:0]    compare_q;
	logic [VAL_W-1:0]    reload_q;

	logic [SAMPLE_W-1:0] inv;
	logic [SAMPLE_W-1:0] clamped;
	logic [CLAMP_W-1:0]  eighths;
	logic [PROD_W-1:0]   prod;
	logic [LEVEL_W-1:0]  level;

	panel_view_t         view;
	logic                apply;
	logic                div_start;
	logic [VAL_W-1:0]    div_dividend;
	logic [LEVEL_W-1:0]  div_divisor;
	logic                div_done;
	logic [VAL_W-1:0]    div_quotient;
	logic                out_load;

	// Knob level. The sample is inverted and clamped to 4000, then divided
	// by 40: a shift by three leaves at most 500, and for values that small
	// multiplying by 205 and dropping ten bits is an exact divide by five.
	assign inv     = KNOB_FULL - sample_q;
	assign clamped = (inv > LEVEL_CLAMP) ? LEVEL_CLAMP : inv;
	assign eighths = clamped[SAMPLE_W-1:PRE_SHIFT];
	assign prod    = PROD_W'(eighths) * PROD_W'(RECIP_FIVE);
	assign level   = prod[RECIP_SHIFT +: LEVEL_W];

	assign apply = (state_q == ST_APPLY);

	pfsc_panel #(
		.CHANNELS (CHANNELS)
	) u_panel (
		.clk    (clk),
		.arst_n (arst_n),
		.apply  (apply),
		.level  (level),
		.key    (key_q),
		.view   (view)
	);

	// Both divisions share one divider. The divisor is the shown frequency,
	// which the panel never stores as zero; a zero would still divide by one.
	assign div_start    = (state_q == ST_DIV_CMP) || (state_q == ST_DIV_RLD);
	assign div_divisor  = (view.freq == '0) ? LEVEL_W'(1) : view.freq;
	assign div_dividend = (state_q == ST_DIV_CMP) ? VAL_W'(view.duty) * PCT_SCALE
	                                              : RELOAD_NUM;

	pfsc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// The output register is loaded once the result is complete and the
	// previous result is gone or leaving in this cycle.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_DIV_CMP;
				end
				ST_DIV_CMP: begin
					state_q <= ST_WAIT_CMP;
				end
				ST_WAIT_CMP: begin
					if (div_done) state_q <= ST_DIV_RLD;
				end
				ST_DIV_RLD: begin
					state_q <= ST_WAIT_RLD;
				end
				ST_WAIT_RLD: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and the first quotient.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sample_q <= knob_sample;
			key_q    <= key_code;
		end
		if (state_q == ST_WAIT_CMP && div_done) begin
			cmp_q <= div_quotient;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload. The panel state stays put until the next request is
	// applied, so it is read straight from the panel at load time.
	always_ff @(posedge clk) begin
		if (out_load) begin
			channel_q <= view.channel;
			editing_q <= view.editing;
			field_q   <= view.field;
			duty_q    <= view.duty;
			freq_q    <= view.freq;
			changed_q <= view.changed;
			compare_q <= cmp_q;
			reload_q  <= div_quotient;
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign selected_channel = channel_q;
	assign editing          = editing_q;
	assign edited_field     = field_q;
	assign shown_duty       = duty_q;
	assign shown_freq       = freq_q;
	assign setting_changed  = changed_q;
	assign compare_value    = compare_q;
	assign reload_value     = reload_q;

	// A new result appears only when the sequencer hands one over.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result appeared outside the hand-over state");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT_CMP || state_q == ST_WAIT_RLD))
		else $error("divider finished outside a wait state");

	// The reload value stays within the range a nonzero frequency allows.
	a_reload_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reload_value >= VAL_W'(100) && reload_value <= RELOAD_NUM)
		else $error("reload value out of range");

	// The compare value is the floor of 100 * duty / freq.
	a_compare_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 21'(compare_value) * 21'(shown_freq) <= 21'(shown_duty) * 21'(100)
		&& (21'(compare_value) + 21'(1)) * 21'(shown_freq) > 21'(shown_duty) * 21'(100))
		else $error("compare value is not the exact quotient");

endmodule
